@@ rtl/core/bql_pkg.sv @@
// ----------------------------------------------------------------------------
// bql_pkg
// Shared types and constants for the biquad low-pass filter: register
// indexes, sequencer states and the control word of the shared MAC.
// ----------------------------------------------------------------------------
package bql_pkg;

    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Delay line format: signed Q16.16
    localparam int DELAY_BITS = 32;
    localparam int DELAY_FRAC = 16;

    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_BYPASS  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_B0 = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_B1 = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_B2 = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A1 = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A2 = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_FB_SUM,
        ST_W0_MUL_B1,
        ST_MUL_B2,
        ST_MUL_B0,
        ST_ACC_SUM,
        ST_FINISH
    } bql_state_t;

    typedef enum logic [2:0] {
        SEL_A1_W1,
        SEL_A2_W2,
        SEL_B1_W1,
        SEL_B2_W2,
        SEL_B0_W0
    } bql_sel_t;

    typedef struct packed {
        logic     mul_en;
        bql_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     w0_load;
        logic     finish;
    } bql_ctl_t;

endpackage

@@ rtl/core/biquad_lowpass_filter.sv @@
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Direct-form-II biquad low-pass filter in fixed point, with one shared
// multiplier for the five coefficient products of each sample.
// ----------------------------------------------------------------------------
// Sequence: a filtered sample runs the five products and two accumulate steps
//   through the single multiplier; a bypassed one goes straight to finish.
// A new sample is taken only after the last one leaves the finish step, which
//   waits for room in the output register.
// Reset (aresetn low, synchronous): bypass set, coefficients and both delays
//   cleared, output channel empty.
module biquad_lowpass_filter
    import bql_pkg::*;
#(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input  logic                          cfg_wr_en,
    input  logic [REG_IDX_BITS-1:0]       cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]     cfg_wdata
);

    localparam int COEF_W  = COEF_FRAC_BITS + 2;
    localparam int ACC_W   = COEF_W + DELAY_BITS + 2;
    localparam int FBR_W   = ACC_W - COEF_FRAC_BITS;
    localparam int XW      = SAMPLE_BITS + DELAY_FRAC;
    localparam int W0_W    = ((XW > FBR_W) ? XW : FBR_W) + 1;
    localparam int Y_SHIFT = DELAY_FRAC + COEF_FRAC_BITS;
    localparam int Y_W     = ACC_W - Y_SHIFT;
    localparam int YE_W    = (Y_W > SAMPLE_BITS) ? Y_W : SAMPLE_BITS;

    localparam logic signed [ACC_W-1:0] FB_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (Y_SHIFT - 1);

    logic                     bypass;
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;

    bql_ctl_t seq_ctl;
    logic     accept;
    logic     out_free;

    logic signed [COEF_W-1:0]     mac_coef;
    logic signed [DELAY_BITS-1:0] mac_operand;
    logic signed [ACC_W-1:0]      acc;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          byp_reg;
    logic signed [DELAY_BITS-1:0]  w0_reg;
    logic signed [DELAY_BITS-1:0]  delay_one_reg;
    logic signed [DELAY_BITS-1:0]  delay_two_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_out_reg;

    logic signed [ACC_W-1:0]      fb_biased;
    logic signed [FBR_W-1:0]      fb_round;
    logic signed [XW-1:0]         x_shift;
    logic signed [W0_W-1:0]       w0_wide;
    logic [W0_W-DELAY_BITS:0]     w0_upper;
    logic signed [DELAY_BITS-1:0] w0_next;

    logic signed [ACC_W-1:0]       y_biased;
    logic signed [Y_W-1:0]         y_round;
    logic signed [YE_W-1:0]        y_ext;
    logic [YE_W-SAMPLE_BITS:0]     y_upper;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    bql_regs #(
        .COEF_W (COEF_W)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .bypass    (bypass),
        .coef_b0   (coef_b0),
        .coef_b1   (coef_b1),
        .coef_b2   (coef_b2),
        .coef_a1   (coef_a1),
        .coef_a2   (coef_a2)
    );

    bql_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .bypass   (bypass),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctl      (seq_ctl)
    );

    always_comb begin
        case (seq_ctl.mul_sel)
            SEL_A1_W1: begin
                mac_coef    = coef_a1;
                mac_operand = delay_one_reg;
            end
            SEL_A2_W2: begin
                mac_coef    = coef_a2;
                mac_operand = delay_two_reg;
            end
            SEL_B1_W1: begin
                mac_coef    = coef_b1;
                mac_operand = delay_one_reg;
            end
            SEL_B2_W2: begin
                mac_coef    = coef_b2;
                mac_operand = delay_two_reg;
            end
            SEL_B0_W0: begin
                mac_coef    = coef_b0;
                mac_operand = w0_reg;
            end
            default: begin
                mac_coef    = coef_a1;
                mac_operand = delay_one_reg;
            end
        endcase
    end

    bql_mac #(
        .COEF_W (COEF_W),
        .DATA_W (DELAY_BITS),
        .ACC_W  (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .ctl     (seq_ctl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .acc     (acc)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // w0 = x*2^16 - round(fb), saturated to the delay width
    assign fb_biased = acc + FB_HALF;
    assign fb_round  = fb_biased[ACC_W-1:COEF_FRAC_BITS];
    assign x_shift   = {x_reg, {DELAY_FRAC{1'b0}}};
    assign w0_wide   = W0_W'(x_shift) - W0_W'(fb_round);
    assign w0_upper  = w0_wide[W0_W-1:DELAY_BITS-1];

    always_comb begin
        if (!w0_wide[W0_W-1] && (|w0_upper)) begin
            w0_next = {1'b0, {(DELAY_BITS-1){1'b1}}};
        end else if (w0_wide[W0_W-1] && !(&w0_upper)) begin
            w0_next = {1'b1, {(DELAY_BITS-1){1'b0}}};
        end else begin
            w0_next = w0_wide[DELAY_BITS-1:0];
        end
    end

    // y = round(acc) saturated to the sample width
    assign y_biased = acc + Y_HALF;
    assign y_round  = y_biased[ACC_W-1:Y_SHIFT];
    assign y_ext    = YE_W'(y_round);
    assign y_upper  = y_ext[YE_W-1:SAMPLE_BITS-1];

    always_comb begin
        if (!y_ext[YE_W-1] && (|y_upper)) begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (y_ext[YE_W-1] && !(&y_upper)) begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y_sat = y_ext[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_sample_in;
        end
        if (seq_ctl.w0_load) begin
            w0_reg <= w0_next;
        end
        if (seq_ctl.finish && out_free) begin
            m_sample_out_reg <= byp_reg ? x_reg : y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg       <= 1'b1;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                byp_reg <= bypass;
            end
            if (seq_ctl.finish && out_free) begin
                m_valid_reg <= 1'b1;
                // advance the delay line only for filtered samples
                if (!byp_reg) begin
                    delay_two_reg <= delay_one_reg;
                    delay_one_reg <= w0_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("new transaction taken while a sample is in work");

    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(seq_ctl.finish))
        else $error("output valid raised outside the finish step");

    a_bypass_holds_delays: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_ctl.finish && out_free && byp_reg)
            |=> ($stable(delay_one_reg) && $stable(delay_two_reg)))
        else $error("bypassed sample changed the delay line");

    a_idle_mac_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!seq_ctl.mul_en && !seq_ctl.acc_load && !seq_ctl.acc_add))
        else $error("MAC active while sequencer is idle");
`endif

endmodule

@@ rtl/core/bql_regs.sv @@
// ----------------------------------------------------------------------------
// bql_regs
// Configuration register file: bypass flag and the five signed coefficients.
// ----------------------------------------------------------------------------
module bql_regs
    import bql_pkg::*;
#(
    parameter int COEF_W = DEF_COEF_FRAC_BITS + 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [REG_IDX_BITS-1:0]  cfg_index,
    input  logic [COEF_W-1:0]        cfg_wdata,
    output logic                     bypass,
    output logic signed [COEF_W-1:0] coef_b0,
    output logic signed [COEF_W-1:0] coef_b1,
    output logic signed [COEF_W-1:0] coef_b2,
    output logic signed [COEF_W-1:0] coef_a1,
    output logic signed [COEF_W-1:0] coef_a2
);

    logic                     bypass_reg;
    logic signed [COEF_W-1:0] coef_b0_reg;
    logic signed [COEF_W-1:0] coef_b1_reg;
    logic signed [COEF_W-1:0] coef_b2_reg;
    logic signed [COEF_W-1:0] coef_a1_reg;
    logic signed [COEF_W-1:0] coef_a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg  <= 1'b1;
            coef_b0_reg <= '0;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BYPASS:  bypass_reg  <= cfg_wdata[0];
                REG_COEF_B0: coef_b0_reg <= cfg_wdata;
                REG_COEF_B1: coef_b1_reg <= cfg_wdata;
                REG_COEF_B2: coef_b2_reg <= cfg_wdata;
                REG_COEF_A1: coef_a1_reg <= cfg_wdata;
                REG_COEF_A2: coef_a2_reg <= cfg_wdata;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign bypass  = bypass_reg;
    assign coef_b0 = coef_b0_reg;
    assign coef_b1 = coef_b1_reg;
    assign coef_b2 = coef_b2_reg;
    assign coef_a1 = coef_a1_reg;
    assign coef_a2 = coef_a2_reg;

endmodule

@@ rtl/core/bql_mac.sv @@
// ----------------------------------------------------------------------------
// bql_mac
// Shared multiply-accumulate unit: one registered coefficient-by-delay
// product per cycle while mul_en is set, folded into a wide accumulator on the next cycle.
// ----------------------------------------------------------------------------
module bql_mac
    import bql_pkg::*;
#(
    parameter int COEF_W = DEF_COEF_FRAC_BITS + 2,
    parameter int DATA_W = DELAY_BITS,
    parameter int ACC_W  = DEF_COEF_FRAC_BITS + 2 + DELAY_BITS + 2
) (
    input  logic                     aclk,
    input  bql_ctl_t                 ctl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [DATA_W-1:0] operand,
    output logic signed [ACC_W-1:0]  acc
);

    localparam int PROD_W = COEF_W + DATA_W;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_reg;

    assign prod_next = PROD_W'(coef) * PROD_W'(operand);
    assign prod_ext  = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctl.acc_load) begin
            acc_reg <= prod_ext;
        end else if (ctl.acc_add) begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    assign acc = acc_reg;

endmodule

@@ rtl/core/bql_seq.sv @@
// ----------------------------------------------------------------------------
// bql_seq
// Sequencer: steps the shared MAC through the feedback and feedforward
// products of a sample (none in bypass) and hands it to the output register.
// ----------------------------------------------------------------------------
module bql_seq
    import bql_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     bypass,
    input  logic     out_free,
    output logic     s_ready,
    output bql_ctl_t ctl
);

    bql_state_t state_reg;
    bql_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        ctl.mul_en   = 1'b0;
        ctl.mul_sel  = SEL_A1_W1;
        ctl.acc_load = 1'b0;
        ctl.acc_add  = 1'b0;
        ctl.w0_load  = 1'b0;
        ctl.finish   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = bypass ? ST_FINISH : ST_MUL_A1;
                end
            end
            ST_MUL_A1: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_A1_W1;
                state_next  = ST_MUL_A2;
            end
            ST_MUL_A2: begin
                ctl.mul_en   = 1'b1;
                ctl.mul_sel  = SEL_A2_W2;
                ctl.acc_load = 1'b1;
                state_next   = ST_FB_SUM;
            end
            ST_FB_SUM: begin
                ctl.acc_add = 1'b1;
                state_next  = ST_W0_MUL_B1;
            end
            ST_W0_MUL_B1: begin
                // w0 is taken from the feedback sum while b1*w1 starts
                ctl.w0_load = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_B1_W1;
                state_next  = ST_MUL_B2;
            end
            ST_MUL_B2: begin
                ctl.mul_en   = 1'b1;
                ctl.mul_sel  = SEL_B2_W2;
                ctl.acc_load = 1'b1;
                state_next   = ST_MUL_B0;
            end
            ST_MUL_B0: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_B0_W0;
                ctl.acc_add = 1'b1;
                state_next  = ST_ACC_SUM;
            end
            ST_ACC_SUM: begin
                ctl.acc_add = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                ctl.finish = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ tb/biquad_output_checker.sv @@
// ----------------------------------------------------------------------------
// biquad_output_checker
// Watches the sample, result and register ports of the biquad low-pass
// filter. It keeps its own fixed-point filter state, predicts each output
// sample and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module biquad_output_checker
    import bql_pkg::*;
#(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input  logic                          cfg_wr_en,
    input  logic [REG_IDX_BITS-1:0]       cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]     cfg_wdata,
    output int                            error_count,
    output int                            pending,
    output int                            results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    logic    bypass_q;
    longint  coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
    longint  w1_q, w2_q;
    sample_t expected_samples[$];
    sample_t want;
    int      errs;
    int      seen;

    function automatic longint saturate(input longint v, input int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // round half up: add half an LSB, then floor
    function automatic longint round_off(input longint v, input int bits);
        return (v + (longint'(1) <<< (bits - 1))) >>> bits;
    endfunction

    function automatic sample_t filter_sample(input sample_t x);
        longint fb, w0, acc;
        if (bypass_q) return x;
        fb  = coef_a1_q * w1_q + coef_a2_q * w2_q;
        w0  = saturate((longint'(x) <<< DELAY_FRAC) - round_off(fb, COEF_FRAC_BITS),
                       DELAY_BITS);
        acc = coef_b0_q * w0 + coef_b1_q * w1_q + coef_b2_q * w2_q;
        w2_q = w1_q;
        w1_q = w0;
        return sample_t'(saturate(round_off(acc, DELAY_FRAC + COEF_FRAC_BITS),
                                  SAMPLE_BITS));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            bypass_q  = 1'b1;
            coef_b0_q = 0;
            coef_b1_q = 0;
            coef_b2_q = 0;
            coef_a1_q = 0;
            coef_a2_q = 0;
            w1_q      = 0;
            w2_q      = 0;
            expected_samples.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BYPASS:  bypass_q  = cfg_wdata[0];
                    REG_COEF_B0: coef_b0_q = longint'(signed'(cfg_wdata));
                    REG_COEF_B1: coef_b1_q = longint'(signed'(cfg_wdata));
                    REG_COEF_B2: coef_b2_q = longint'(signed'(cfg_wdata));
                    REG_COEF_A1: coef_a1_q = longint'(signed'(cfg_wdata));
                    REG_COEF_A2: coef_a2_q = longint'(signed'(cfg_wdata));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                seen++;
                if (expected_samples.size() == 0) begin
                    errs++;
                    $error("sample_out: no transaction pending, actual %0d", m_sample_out);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_sample_out !== want) begin
                        errs++;
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want, m_sample_out);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_samples.push_back(filter_sample(s_sample_in));
        end
        error_count  <= errs;
        pending      <= expected_samples.size();
        results_seen <= seen;
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the biquad low-pass filter: directed samples at the range
// limits under bypass, a Butterworth set and saturating coefficients, then
// random phases with random register settings and random stalls on both
// channels. Checking is done by biquad_output_checker.
// ----------------------------------------------------------------------------
module testbench;
    import bql_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = DEF_SAMPLE_BITS;
    localparam int CW = DEF_COEF_FRAC_BITS + 2;

    typedef logic signed [SB-1:0] sample_t;
    typedef logic [CW-1:0]        coef_t;

    typedef enum int {
        COEF_LOWPASS,
        COEF_WILD,
        COEF_MILD
    } coef_mode_t;

    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam coef_t   COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(CW-1){1'b0}}};

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int LONG_HOLD       = 600;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 300000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    sample_t                 s_sample_in;
    logic                    m_valid;
    logic                    m_ready;
    sample_t                 m_sample_out;
    logic                    cfg_wr_en;
    logic [REG_IDX_BITS-1:0] cfg_index;
    coef_t                   cfg_wdata;

    int   error_count;
    int   pending;
    int   results_seen;

    logic steady;
    int   hold_req;
    int   hold_seen;
    int   cycles;
    int   sent;
    int   settings;
    int   phase;
    int   n;
    sample_t    last_sample;
    coef_mode_t mode;
    coef_t      c_b0, c_b1, c_b2, c_a1, c_a2;
    logic       byp;

    biquad_lowpass_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    biquad_output_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .error_count  (error_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic sample_t pick_sample(input sample_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return sample_t'($urandom);
        if (r < 65) return sample_t'(int'($urandom_range(0, 512)) - 256);
        if (r < 75) return ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
        return prev;  // hold for step-like runs
    endfunction

    task automatic pick_lowpass(output coef_t b0, b1, b2, a1, a2);
        case ($urandom_range(0, 2))
            0: begin
                b0 = coef_t'(4421);  b1 = coef_t'(8842);  b2 = coef_t'(4421);
                a1 = coef_t'(-74907); a2 = coef_t'(27053);
            end
            1: begin
                b0 = coef_t'(237);   b1 = coef_t'(474);   b2 = coef_t'(237);
                a1 = coef_t'(-119452); a2 = coef_t'(54865);
            end
            default: begin
                b0 = coef_t'(19195); b1 = coef_t'(38390); b2 = coef_t'(19195);
                a1 = coef_t'(0);     a2 = coef_t'(11244);
            end
        endcase
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input coef_t data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // only call while the block is idle
    task automatic load_filter(input logic bypass_bit, input coef_t b0, b1, b2, a1, a2);
        coef_t word;
        word    = coef_t'($urandom);
        word[0] = bypass_bit;
        write_reg(REG_COEF_B0, b0);
        write_reg(REG_COEF_B1, b1);
        write_reg(REG_COEF_B2, b2);
        write_reg(REG_COEF_A1, a1);
        write_reg(REG_COEF_A2, a2);
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  coef_t'($urandom));
        write_reg(REG_BYPASS, word);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings++;
    endtask

    task automatic send_sample(input sample_t v);
        int gap;
        s_valid     <= 1'b1;
        s_sample_in <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        last_sample = v;
        gap = (steady || $urandom_range(0, 1) == 1) ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid, wait for every pending result, then let the sequencer settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        hold_seen = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycles, pending);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sent        = 0;
        settings    = 0;
        last_sample = '0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_sample_in <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_BYPASS;
        cfg_wdata   <= '0;
        steady      <= 1'b0;
        hold_req    <= 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bypass is on after reset
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(sample_t'(0));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(1));
        drain();

        // Butterworth at a tenth of the sample rate: step up, step down
        load_filter(1'b0, coef_t'(4421), coef_t'(8842), coef_t'(4421),
                    coef_t'(-74907), coef_t'(27053));
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (4) send_sample(SAMPLE_MIN);
        repeat (2) send_sample(sample_t'(0));
        drain();

        // runaway feedback: delays and output hit saturation
        load_filter(1'b0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(1));
        drain();
        load_filter(1'b0, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(sample_t'(0));
        drain();

        // bypass with loaded delays: they must survive untouched
        load_filter(1'b1, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        send_sample(sample_t'(12345));
        send_sample(sample_t'(-1));
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            mode = coef_mode_t'($urandom_range(0, 2));
            case (mode)
                COEF_LOWPASS: pick_lowpass(c_b0, c_b1, c_b2, c_a1, c_a2);
                COEF_WILD: begin
                    c_b0 = coef_t'($urandom); c_b1 = coef_t'($urandom);
                    c_b2 = coef_t'($urandom); c_a1 = coef_t'($urandom);
                    c_a2 = coef_t'($urandom);
                end
                default: begin
                    c_b0 = coef_t'($urandom); c_b1 = coef_t'($urandom);
                    c_b2 = coef_t'($urandom);
                    c_a1 = coef_t'(int'($urandom_range(0, 65536)) - 32768);
                    c_a2 = coef_t'(int'($urandom_range(0, 65536)) - 32768);
                end
            endcase
            byp = (phase == 5) || ($urandom_range(0, 7) == 0);
            load_filter(byp, c_b0, c_b1, c_b2, c_a1, c_a2);

            steady <= (phase == 0);
            if (phase == 2)
                hold_req <= hold_req + 1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // pause mid-phase until every result is out
                if (phase == 4 && n == ITEMS_PER_PHASE / 2)
                    drain();
                send_sample(pick_sample(last_sample));
            end
            drain();
        end
        steady <= 1'b0;

        $display("%0d samples sent and %0d results checked across %0d register settings",
                 sent, results_seen, settings);
        $display("(bypass, Butterworth sets, saturating and random coefficients)");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
